>>> hw/rtl/snfcb_pkg.sv
// ----------------------------------------------------------------------------
// snfcb_pkg
// Shared types, codes and frame helpers for the serial NOR command builder.
// ----------------------------------------------------------------------------
package snfcb_pkg;

  typedef enum logic [3:0] {
    KIND_READ      = 4'd0,
    KIND_QUAD_READ = 4'd1,
    KIND_PROGRAM   = 4'd2,
    KIND_ERASE     = 4'd3,
    KIND_READ_ID   = 4'd4,
    KIND_STATUS1   = 4'd5,
    KIND_STATUS2   = 4'd6,
    KIND_UNIQUE_ID = 4'd7,
    KIND_WREN      = 4'd8,
    KIND_WRDIS     = 4'd9,
    KIND_RESET     = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    CFG_CHIP_SIZE   = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_SECTOR_SIZE = 2'd2,
    CFG_PAGE_SIZE   = 2'd3
  } cfg_index_t;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_LEN   = 2'd1;
  localparam logic [1:0] STATUS_BAD_ALIGN = 2'd2;

  localparam logic [7:0] OP_FAST_READ    = 8'h0b;
  localparam logic [7:0] OP_QUAD_READ    = 8'heb;
  localparam logic [7:0] OP_PAGE_PROG    = 8'h02;
  localparam logic [7:0] OP_SECTOR_ERASE = 8'h20;
  localparam logic [7:0] OP_BLOCK_ERASE  = 8'hd8;
  localparam logic [7:0] OP_CHIP_ERASE   = 8'hc7;
  localparam logic [7:0] OP_WREN         = 8'h06;
  localparam logic [7:0] OP_WRDI         = 8'h04;
  localparam logic [7:0] OP_RDSR1        = 8'h05;
  localparam logic [7:0] OP_RDSR2        = 8'h35;
  localparam logic [7:0] OP_RDID         = 8'h9f;
  localparam logic [7:0] OP_RDUID        = 8'h4b;
  localparam logic [7:0] OP_RESET_EN     = 8'h66;
  localparam logic [7:0] OP_RESET_DEV    = 8'h99;

  localparam logic [2:0] LINES_NONE   = 3'd0;
  localparam logic [2:0] LINES_SINGLE = 3'd1;
  localparam logic [2:0] LINES_QUAD   = 3'd4;

  localparam logic [2:0] ADDR_BYTES_NONE = 3'd0;
  localparam logic [2:0] ADDR_BYTES_3    = 3'd3;
  localparam logic [2:0] ADDR_BYTES_4    = 3'd4;

  localparam logic [4:0] DUMMY_FAST_READ = 5'd8;
  localparam logic [4:0] DUMMY_QUAD_READ = 5'd6;

  localparam logic [12:0] PAGE_CAP = 13'd4096;
  localparam logic [3:0]  PAGE_CAP_LOG2 = 4'd12;

  localparam logic [4:0] RESET_CHIP_LOG2   = 5'd23;
  localparam logic [4:0] RESET_BLOCK_LOG2  = 5'd16;
  localparam logic [4:0] RESET_SECTOR_LOG2 = 5'd12;
  localparam logic [3:0] RESET_PAGE_LOG2   = 4'd8;

  typedef struct packed {
    logic [7:0]  opcode;
    logic        instruction_lines;
    logic [2:0]  address_lines;
    logic [2:0]  address_bytes;
    logic [23:0] frame_address;
    logic [2:0]  data_lines;
    logic [4:0]  dummy_cycles;
    logic [12:0] data_count;
    logic        writes_data;
    logic        last;
    logic [1:0]  status;
  } frame_t;

  function automatic frame_t make_frame(
    input logic [7:0]  op,
    input logic [2:0]  al,
    input logic [2:0]  ab,
    input logic [23:0] addr,
    input logic [2:0]  dl,
    input logic [4:0]  dc,
    input logic [12:0] cnt,
    input logic        wr,
    input logic        lst
  );
    frame_t f;
    f.opcode            = op;
    f.instruction_lines = 1'b1;
    f.address_lines     = al;
    f.address_bytes     = ab;
    f.frame_address     = addr;
    f.data_lines        = dl;
    f.dummy_cycles      = dc;
    f.data_count        = cnt;
    f.writes_data       = wr;
    f.last              = lst;
    f.status            = STATUS_OK;
    return f;
  endfunction

  function automatic frame_t make_error(input logic [1:0] code);
    frame_t f;
    f        = '0;
    f.last   = 1'b1;
    f.status = code;
    return f;
  endfunction

endpackage

>>> hw/rtl/snfcb_req_if.sv
// ----------------------------------------------------------------------------
// snfcb_req_if
// Request channel: kind, address and length with valid/ready.
// ----------------------------------------------------------------------------
interface snfcb_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [23:0] address;
  logic [24:0] length;

  modport source (output valid, kind, address, length, input ready);
  modport sink   (input valid, kind, address, length, output ready);
endinterface

>>> hw/rtl/snfcb_frame_if.sv
// ----------------------------------------------------------------------------
// snfcb_frame_if
// Frame channel: one command frame or error result with valid/ready.
// ----------------------------------------------------------------------------
interface snfcb_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  opcode;
  logic        instruction_lines;
  logic [2:0]  address_lines;
  logic [2:0]  address_bytes;
  logic [23:0] frame_address;
  logic [2:0]  data_lines;
  logic [4:0]  dummy_cycles;
  logic [12:0] data_count;
  logic        writes_data;
  logic        last;
  logic [1:0]  status;

  modport source (
    output valid, opcode, instruction_lines, address_lines, address_bytes,
           frame_address, data_lines, dummy_cycles, data_count, writes_data,
           last, status,
    input  ready
  );
  modport sink (
    input  valid, opcode, instruction_lines, address_lines, address_bytes,
           frame_address, data_lines, dummy_cycles, data_count, writes_data,
           last, status,
    output ready
  );
endinterface

>>> hw/rtl/snfcb_cfg_if.sv
// ----------------------------------------------------------------------------
// snfcb_cfg_if
// Configuration write channel: register index and data with valid/ready.
// ----------------------------------------------------------------------------
interface snfcb_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [4:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/spi_nor_flash_command_builder_core.sv
// ----------------------------------------------------------------------------
// spi_nor_flash_command_builder_core
// The request is held in the input register, decoded, and its first frame is
// offered from the output register. Throughput: one request per cycle when it
// yields one frame and the output is not stalled; one that yields two (write
// enable ahead of program or erase, and reset) blocks the next until the hold drains.
// Unknown kinds are dropped. Synchronous reset empties the pipeline and
// loads the default geometry registers.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_builder_core (
  input  logic                 clk,
  input  logic                 rst,
  snfcb_req_if.sink            req,
  snfcb_frame_if.source        rsp,
  snfcb_cfg_if.sink            cfg
);
  import snfcb_pkg::*;

  logic [4:0] chip_log2;
  logic [4:0] block_log2;
  logic [4:0] sector_log2;
  logic [3:0] page_log2;

  logic        in_valid;
  logic [3:0]  in_kind;
  logic [23:0] in_address;
  logic [24:0] in_length;

  logic   out_valid;
  frame_t out_frame;
  logic   hold_valid;
  frame_t hold_frame;

  frame_t     frame0;
  frame_t     frame1;
  logic [1:0] frame_count;

  logic [12:0] page_limit;
  logic        len_bad;
  logic [31:0] chip_bytes;
  logic [31:0] block_bytes;
  logic [31:0] sector_bytes;
  logic [25:0] end_sum;
  logic        chip_hit;
  logic        block_hit;
  logic        sector_hit;

  logic out_pop;
  logic move;

  assign out_pop   = out_valid && rsp.ready;
  assign move      = in_valid && !hold_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || move;
  assign cfg.ready = 1'b1;

  // geometry checks
  always_comb begin
    if (page_log2 >= PAGE_CAP_LOG2) begin
      page_limit = PAGE_CAP;
    end else begin
      page_limit = 13'(13'd1 << page_log2);
    end
    len_bad      = (in_length == 25'd0) || (in_length > {12'd0, page_limit});
    chip_bytes   = 32'd1 << chip_log2;
    block_bytes  = 32'd1 << block_log2;
    sector_bytes = 32'd1 << sector_log2;
    end_sum      = {2'd0, in_address} + {1'd0, in_length};
    chip_hit     = ({7'd0, in_length} == chip_bytes) && (in_address == 24'd0);
    block_hit    = ({7'd0, in_length} == block_bytes) &&
                   (({8'd0, in_address} & (block_bytes - 32'd1)) == 32'd0);
    sector_hit   = ({7'd0, in_length} == sector_bytes) &&
                   (({8'd0, in_address} & (sector_bytes - 32'd1)) == 32'd0);
  end

  // frame decode
  always_comb begin
    frame0      = make_error(STATUS_BAD_LEN);
    frame1      = make_frame(OP_WREN, LINES_NONE, ADDR_BYTES_NONE, 24'd0, LINES_NONE,
                             5'd0, 13'd0, 1'b0, 1'b1);
    frame_count = 2'd1;
    case (in_kind)
      KIND_READ: begin
        if (!len_bad) begin
          frame0 = make_frame(OP_FAST_READ, LINES_SINGLE, ADDR_BYTES_3, in_address,
                              LINES_SINGLE, DUMMY_FAST_READ, in_length[12:0], 1'b0,
                              1'b1);
        end
      end
      KIND_QUAD_READ: begin
        if (!len_bad) begin
          frame0 = make_frame(OP_QUAD_READ, LINES_QUAD, ADDR_BYTES_3, in_address,
                              LINES_QUAD, DUMMY_QUAD_READ, in_length[12:0], 1'b0,
                              1'b1);
        end
      end
      KIND_PROGRAM: begin
        if (!len_bad && ({6'd0, end_sum} < chip_bytes)) begin
          frame0      = make_frame(OP_WREN, LINES_NONE, ADDR_BYTES_NONE, 24'd0,
                                   LINES_NONE, 5'd0, 13'd0, 1'b0, 1'b0);
          frame1      = make_frame(OP_PAGE_PROG, LINES_SINGLE, ADDR_BYTES_3,
                                   in_address, LINES_SINGLE, 5'd0, in_length[12:0],
                                   1'b1, 1'b1);
          frame_count = 2'd2;
        end
      end
      KIND_ERASE: begin
        frame0 = make_frame(OP_WREN, LINES_NONE, ADDR_BYTES_NONE, 24'd0, LINES_NONE,
                            5'd0, 13'd0, 1'b0, 1'b0);
        frame_count = 2'd2;
        if (chip_hit) begin
          frame1 = make_frame(OP_CHIP_ERASE, LINES_NONE, ADDR_BYTES_NONE, 24'd0,
                              LINES_NONE, 5'd0, 13'd0, 1'b0, 1'b1);
        end else if (block_hit) begin
          frame1 = make_frame(OP_BLOCK_ERASE, LINES_SINGLE, ADDR_BYTES_3, in_address,
                              LINES_NONE, 5'd0, 13'd0, 1'b0, 1'b1);
        end else if (sector_hit) begin
          frame1 = make_frame(OP_SECTOR_ERASE, LINES_SINGLE, ADDR_BYTES_3, in_address,
                              LINES_NONE, 5'd0, 13'd0, 1'b0, 1'b1);
        end else begin
          frame0      = make_error(STATUS_BAD_ALIGN);
          frame_count = 2'd1;
        end
      end
      KIND_READ_ID: begin
        frame0 = make_frame(OP_RDID, LINES_NONE, ADDR_BYTES_NONE, 24'd0, LINES_SINGLE,
                            5'd0, 13'd3, 1'b0, 1'b1);
      end
      KIND_STATUS1: begin
        frame0 = make_frame(OP_RDSR1, LINES_NONE, ADDR_BYTES_NONE, 24'd0, LINES_SINGLE,
                            5'd0, 13'd1, 1'b0, 1'b1);
      end
      KIND_STATUS2: begin
        frame0 = make_frame(OP_RDSR2, LINES_NONE, ADDR_BYTES_NONE, 24'd0, LINES_SINGLE,
                            5'd0, 13'd1, 1'b0, 1'b1);
      end
      KIND_UNIQUE_ID: begin
        frame0 = make_frame(OP_RDUID, LINES_SINGLE, ADDR_BYTES_4, 24'd0, LINES_SINGLE,
                            5'd0, 13'd8, 1'b0, 1'b1);
      end
      KIND_WREN: begin
        frame0 = make_frame(OP_WREN, LINES_NONE, ADDR_BYTES_NONE, 24'd0, LINES_NONE,
                            5'd0, 13'd0, 1'b0, 1'b1);
      end
      KIND_WRDIS: begin
        frame0 = make_frame(OP_WRDI, LINES_NONE, ADDR_BYTES_NONE, 24'd0, LINES_NONE,
                            5'd0, 13'd0, 1'b0, 1'b1);
      end
      KIND_RESET: begin
        frame0      = make_frame(OP_RESET_EN, LINES_NONE, ADDR_BYTES_NONE, 24'd0,
                                 LINES_NONE, 5'd0, 13'd0, 1'b0, 1'b0);
        frame1      = make_frame(OP_RESET_DEV, LINES_NONE, ADDR_BYTES_NONE, 24'd0,
                                 LINES_NONE, 5'd0, 13'd0, 1'b0, 1'b1);
        frame_count = 2'd2;
      end
      default: begin
        frame_count = 2'd0;
      end
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chip_log2   <= RESET_CHIP_LOG2;
      block_log2  <= RESET_BLOCK_LOG2;
      sector_log2 <= RESET_SECTOR_LOG2;
      page_log2   <= RESET_PAGE_LOG2;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_CHIP_SIZE:   chip_log2   <= cfg.data;
        CFG_BLOCK_SIZE:  block_log2  <= cfg.data;
        CFG_SECTOR_SIZE: sector_log2 <= cfg.data;
        CFG_PAGE_SIZE:   page_log2   <= cfg.data[3:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      in_kind    <= req.kind;
      in_address <= req.address;
      in_length  <= req.length;
    end
  end

  // output register and second-frame hold
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (move) begin
      out_valid  <= (frame_count != 2'd0);
      hold_valid <= (frame_count == 2'd2);
    end else if (out_pop) begin
      out_valid  <= hold_valid;
      hold_valid <= 1'b0;
    end
    if (move) begin
      out_frame  <= frame0;
      hold_frame <= frame1;
    end else if (out_pop) begin
      out_frame  <= hold_frame;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.opcode            = out_frame.opcode;
  assign rsp.instruction_lines = out_frame.instruction_lines;
  assign rsp.address_lines     = out_frame.address_lines;
  assign rsp.address_bytes     = out_frame.address_bytes;
  assign rsp.frame_address     = out_frame.frame_address;
  assign rsp.data_lines        = out_frame.data_lines;
  assign rsp.dummy_cycles      = out_frame.dummy_cycles;
  assign rsp.data_count        = out_frame.data_count;
  assign rsp.writes_data       = out_frame.writes_data;
  assign rsp.last              = out_frame.last;
  assign rsp.status            = out_frame.status;

endmodule
